// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the timer pool RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define OST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define OST_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/ost_pkg.sv -----
// Types and constants of the one-shot timer pool.
package ost_pkg;

  localparam int unsigned CycW   = 32;
  localparam int unsigned TotalW = 64;
  localparam int unsigned SlotW  = 3;
  localparam int unsigned MaskW  = 8;

  // Request codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_ADVANCE = 2'd0,
    FUNC_ARM     = 2'd1,
    FUNC_STOP    = 2'd2,
    FUNC_RESET   = 2'd3
  } func_t;

  // Command broadcast from the top level to every timer slot.
  typedef struct packed {
    logic              commit;
    func_t             func;
    logic [CycW-1:0]   cycles;
    logic [CycW-1:0]   timeout;
    logic              core;
  } slot_cmd_t;

  // Status returned by one timer slot.
  typedef struct packed {
    logic active;
    logic expire;
    logic core;
  } slot_stat_t;

endpackage

// ----- hdl/ost_slot.sv -----
// One timer slot: elapsed counter, timeout compare and slot state.
module ost_slot (
  input  logic               clk,
  input  logic               rst,
  input  ost_pkg::slot_cmd_t cmd,
  input  logic               arm_sel,
  output ost_pkg::slot_stat_t stat
);

  logic                      active;
  logic                      active_next;
  logic [ost_pkg::CycW-1:0]  elapsed;
  logic [ost_pkg::CycW-1:0]  elapsed_next;
  logic [ost_pkg::CycW-1:0]  timeout;
  logic                      core;
  logic [ost_pkg::CycW:0]    sum;
  logic [ost_pkg::CycW-1:0]  sat_sum;
  logic                      expire;

  // Saturating add of the advanced cycles and the timeout compare.
  always_comb begin
    sum     = {1'b0, elapsed} + {1'b0, cmd.cycles};
    sat_sum = sum[ost_pkg::CycW] ? {ost_pkg::CycW{1'b1}} : sum[ost_pkg::CycW-1:0];
    expire  = active && (cmd.func == ost_pkg::FUNC_ADVANCE) && (sat_sum >= timeout);
  end

  // Next slot state for each request.
  always_comb begin
    active_next  = active;
    elapsed_next = elapsed;
    unique case (cmd.func)
      ost_pkg::FUNC_ADVANCE: begin
        if (active) begin
          if (expire) begin
            active_next  = 1'b0;
            elapsed_next = '0;
          end else begin
            elapsed_next = sat_sum;
          end
        end
      end
      ost_pkg::FUNC_ARM: begin
        if (arm_sel) begin
          active_next  = 1'b1;
          elapsed_next = '0;
        end
      end
      ost_pkg::FUNC_STOP: begin
        active_next = 1'b0;
      end
      ost_pkg::FUNC_RESET: begin
        active_next  = 1'b0;
        elapsed_next = '0;
      end
      default: begin
        active_next = active;
      end
    endcase
  end

  // Slot state registers, updated when a word leaves the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      elapsed <= '0;
    end else if (cmd.commit) begin
      active  <= active_next;
      elapsed <= elapsed_next;
    end
  end

  // Timeout and target core are only read while the slot is active.
  always_ff @(posedge clk) begin
    if (cmd.commit && (cmd.func == ost_pkg::FUNC_ARM) && arm_sel) begin
      timeout <= cmd.timeout;
      core    <= cmd.core;
    end
  end

  assign stat.active = active;
  assign stat.expire = expire;
  assign stat.core   = core;

endmodule

// ----- hdl/ost_prio.sv -----
// Lowest-free-slot priority encoder for arm requests.
module ost_prio #(
  parameter int unsigned NUM_TIMERS = 8,
  parameter int unsigned IDX_W      = 3
) (
  input  logic [NUM_TIMERS-1:0] active,
  output logic [NUM_TIMERS-1:0] sel,
  output logic [IDX_W-1:0]      idx,
  output logic                  full
);

  logic [NUM_TIMERS-1:0] free;
  logic [NUM_TIMERS-1:0] lower_free;

  // One-hot select of the lowest free slot and its binary index.
  always_comb begin
    free       = ~active;
    lower_free = '0;
    sel        = '0;
    idx        = '0;
    for (int i = 1; i < NUM_TIMERS; i++) begin
      lower_free[i] = lower_free[i-1] | free[i-1];
    end
    for (int i = 0; i < NUM_TIMERS; i++) begin
      sel[i] = free[i] & ~lower_free[i];
      if (sel[i]) begin
        idx = IDX_W'(i);
      end
    end
    full = ~|free;
  end

endmodule

// ----- hdl/one_shot_timer_pool.sv -----
// One-shot timer pool: input stage, slot array and result register.
// A word accepted into the input register moves on to the result register once that register is free.
// Throughput: one word per cycle while out_stall is low; the slot adders and compares run in parallel.
// The result register lets a new word enter while the previous result waits.
// Reset (rst, synchronous) frees every slot, clears elapsed counts and the cycle total.
`include "assert_macros.svh"

module one_shot_timer_pool #(
  parameter int unsigned NUM_TIMERS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   func,
  input  logic [ost_pkg::CycW-1:0]     advance_cycles,
  input  logic [ost_pkg::CycW-1:0]     timeout,
  input  logic                         dest_core,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         status,
  output logic [ost_pkg::SlotW-1:0]    slot,
  output logic [ost_pkg::MaskW-1:0]    expired_mask,
  output logic                         irq_core0,
  output logic                         irq_core1,
  output logic [ost_pkg::TotalW-1:0]   cycle_total
);

  localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Input stage.
  logic                         s1_valid;
  ost_pkg::func_t               s1_func;
  logic [ost_pkg::CycW-1:0]     s1_cycles;
  logic [ost_pkg::CycW-1:0]     s1_timeout;
  logic                         s1_core;
  logic                         s1_move;

  // Pool state and slot status.
  logic [ost_pkg::TotalW-1:0]   total;
  logic [ost_pkg::TotalW-1:0]   total_next;
  ost_pkg::slot_cmd_t           cmd;
  ost_pkg::slot_stat_t          stat [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]        active_vec;
  logic [NUM_TIMERS-1:0]        expire_vec;
  logic [NUM_TIMERS-1:0]        core_vec;
  logic [NUM_TIMERS-1:0]        arm_sel;
  logic [IdxW-1:0]              free_idx;
  logic                         full;

  // Result values before the output register.
  logic [IdxW+ost_pkg::SlotW-1:0]       slot_ext;
  logic [NUM_TIMERS+ost_pkg::MaskW-1:0] mask_ext;
  logic                                 status_next;
  logic [ost_pkg::SlotW-1:0]            slot_next;
  logic [ost_pkg::MaskW-1:0]            mask_next;
  logic                                 irq0_next;
  logic                                 irq1_next;

  // Handshake: the input stage drains whenever the result register is free.
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_func    <= ost_pkg::func_t'(func);
      s1_cycles  <= advance_cycles;
      s1_timeout <= timeout;
      s1_core    <= dest_core;
    end
  end

  // Command broadcast to all slots.
  always_comb begin
    cmd.commit  = s1_move;
    cmd.func    = s1_func;
    cmd.cycles  = s1_cycles;
    cmd.timeout = s1_timeout;
    cmd.core    = s1_core;
  end

  // Slot array.
  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_slot
    ost_slot u_slot (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .arm_sel (arm_sel[g]),
      .stat    (stat[g])
    );
    assign active_vec[g] = stat[g].active;
    assign expire_vec[g] = stat[g].expire;
    assign core_vec[g]   = stat[g].core;
  end

  // Lowest free slot for an arm.
  ost_prio #(
    .NUM_TIMERS (NUM_TIMERS),
    .IDX_W      (IdxW)
  ) u_prio (
    .active (active_vec),
    .sel    (arm_sel),
    .idx    (free_idx),
    .full   (full)
  );

  // Running cycle total.
  always_comb begin
    unique case (s1_func)
      ost_pkg::FUNC_ADVANCE: total_next = total + {{(ost_pkg::TotalW-ost_pkg::CycW){1'b0}},
                                                   s1_cycles};
      ost_pkg::FUNC_RESET:   total_next = '0;
      default:               total_next = total;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (s1_move) begin
      total <= total_next;
    end
  end

  // Result fields, cut or padded to their port widths.
  always_comb begin
    slot_ext    = {{ost_pkg::SlotW{1'b0}}, free_idx};
    mask_ext    = {{ost_pkg::MaskW{1'b0}}, expire_vec};
    status_next = 1'b0;
    slot_next   = '0;
    mask_next   = '0;
    irq0_next   = 1'b0;
    irq1_next   = 1'b0;
    unique case (s1_func)
      ost_pkg::FUNC_ADVANCE: begin
        mask_next = mask_ext[ost_pkg::MaskW-1:0];
        irq0_next = |(expire_vec & ~core_vec);
        irq1_next = |(expire_vec & core_vec);
      end
      ost_pkg::FUNC_ARM: begin
        status_next = full;
        slot_next   = full ? '0 : slot_ext[ost_pkg::SlotW-1:0];
      end
      default: begin
        status_next = 1'b0;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      status       <= status_next;
      slot         <= slot_next;
      expired_mask <= mask_next;
      irq_core0    <= irq0_next;
      irq_core1    <= irq1_next;
      cycle_total  <= total_next;
    end
  end

  // Checks on the pool logic.
  `OST_ASSERT(a_arm_free_slot,
    (s1_move && (s1_func == ost_pkg::FUNC_ARM) && !full) |->
      ($onehot(arm_sel) && ((arm_sel & active_vec) == '0)),
    "arm picked a busy slot")
  `OST_ASSERT(a_refused_arm,
    (out_valid && status) |-> ((slot == '0) && (expired_mask == '0)),
    "refused arm carries slot or mask")
  `OST_ASSERT(a_mask_irq,
    (out_valid && (expired_mask != '0)) |-> (irq_core0 || irq_core1),
    "expiry without interrupt")
  `OST_ASSERT_RST(a_reset_empty,
    rst |=> (!out_valid && !s1_valid),
    "pipeline not empty after reset")

endmodule
